// ===== hdl/cpd_pkg.sv =====
// Shared types and constants for the checksummed packet deframer.
// No dependencies; used by cpd_parser and checksummed_packet_deframer.
package cpd_pkg;

  // Parser phase codes.
  localparam logic [1:0] PhLen  = 2'd0;
  localparam logic [1:0] PhSum  = 2'd1;
  localparam logic [1:0] PhCmd  = 2'd2;
  localparam logic [1:0] PhData = 2'd3;

  // Length, checksum and command bytes form the packet header.
  localparam logic [7:0] HdrBytes = 8'd3;

  typedef struct packed {
    logic       is_payload;
    logic [7:0] out_byte;
    logic       last;
    logic       sum_ok;
  } cpd_result_t;

endpackage

// ===== hdl/checksummed_packet_deframer.sv =====
// Top level of the checksummed packet deframer: input register, parser, result register.
// Depends on cpd_pkg and cpd_parser.
//
//   Channel   Signals                                         Direction
//   -------   ---------------------------------------------   ---------
//   in        in_valid_i, in_ready_o, in_byte_i               sink
//   out       out_valid_o, out_ready_i, is_payload_o,
//             out_byte_o, last_o, sum_ok_o                    source
//
// Each received byte is taken into an input register, decoded by the parser in the
// following cycle and, if it is a command or payload byte, written to the result register.
// One byte is accepted per cycle unless the input stalls.
// The input register advances whenever its byte gives no result or the result register
// is empty or being drained. While a result waits, one more byte can still be taken; if
// that held byte also gives a result, the input stalls until the waiting result is taken.
// Reset (rst_ni low, asynchronous) empties both registers and puts the parser back to
// waiting for a length byte with zero counters and sums.
module checksummed_packet_deframer import cpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_payload_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       sum_ok_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  cpd_result_t out_q;

  logic        emit;
  cpd_result_t result;
  logic        advance;
  logic        out_load;

  // The parser commits its state only when the held byte moves on.
  cpd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // The held byte may leave when it gives no result or the result slot will be free.
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign out_load   = advance && emit;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_payload_o = out_q.is_payload;
  assign out_byte_o   = out_q.out_byte;
  assign last_o       = out_q.last;
  assign sum_ok_o     = out_q.sum_ok;

  // The input side stalls only while a byte is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // A stalled result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !out_load)
    else $error("result register overwritten while stalled");

  // The checksum verdict is zero on every byte but the last of a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !sum_ok_o)
    else $error("sum_ok set on a non-final byte");

endmodule

// ===== hdl/cpd_parser.sv =====
// Packet parser state and per-byte decode for the deframer.
// Depends on cpd_pkg.
module cpd_parser import cpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output logic        emit_o,
  output cpd_result_t result_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] expected_sum_q, expected_sum_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic       fin;

  always_comb begin
    phase_d        = phase_q;
    bytes_left_d   = bytes_left_q;
    expected_sum_d = expected_sum_q;
    running_sum_d  = running_sum_q;
    fin            = 1'b0;
    emit_o         = 1'b0;
    result_o       = '0;
    case (phase_q)
      PhLen: begin
        if (byte_i >= HdrBytes) begin
          bytes_left_d = byte_i - HdrBytes;
          phase_d      = PhSum;
        end
      end
      PhSum: begin
        expected_sum_d = byte_i;
        phase_d        = PhCmd;
      end
      PhCmd: begin
        running_sum_d = byte_i;
        fin           = (bytes_left_q == 8'd0);
        phase_d       = fin ? PhLen : PhData;
        emit_o        = 1'b1;
      end
      default: begin
        running_sum_d = running_sum_q + byte_i;
        fin           = (bytes_left_q <= 8'd1);
        bytes_left_d  = fin ? 8'd0 : bytes_left_q - 8'd1;
        if (fin) begin
          phase_d = PhLen;
        end
        emit_o = 1'b1;
      end
    endcase
    result_o.is_payload = (phase_q == PhData);
    result_o.out_byte   = byte_i;
    result_o.last       = fin;
    result_o.sum_ok     = fin && (running_sum_d == expected_sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhLen;
      bytes_left_q   <= 8'd0;
      expected_sum_q <= 8'd0;
      running_sum_q  <= 8'd0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      expected_sum_q <= expected_sum_d;
      running_sum_q  <= running_sum_d;
    end
  end

  // A command byte always moves the parser out of the command phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PhCmd |=> phase_q != PhCmd)
    else $error("parser stayed in command phase");

  // A short length byte leaves the parser waiting for a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PhLen && byte_i < HdrBytes |=> phase_q == PhLen)
    else $error("short length byte was not skipped");

  // Only command and payload bytes produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (phase_q == PhCmd || phase_q == PhData))
    else $error("result from a header byte");

endmodule
